// ===== hdl/wbps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the wildcard byte pattern search: widths, register indexes,
// the cell control struct and the byte compare helpers. No dependencies.
package wbps_pkg;

    localparam int DATA_W    = 8;
    localparam int ADDR_W    = 64;
    localparam int POS_W     = 32;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;
    localparam int PAT_W     = PAT_BYTES * DATA_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_WILDCARD_BYTE  = 3'd1,
        CFG_PATTERN_LOW    = 3'd2,
        CFG_PATTERN_HIGH   = 3'd3,
        CFG_BASE_ADDRESS   = 3'd4,
        CFG_ANCHORED_MODE  = 3'd5
    } t_cfg_reg;

    // per-cell control: shift strobe, compare byte and whether the cell is in use
    typedef struct packed {
        logic              shift;
        logic              active;
        logic [DATA_W-1:0] pat;
        logic [DATA_W-1:0] wild;
    } t_cell_ctrl;

    function automatic logic [DATA_W-1:0] pattern_byte(
        input logic [PAT_W-1:0]     pattern,
        input logic [PAT_IDX_W-1:0] k
    );
        return pattern[{k, 3'b000} +: DATA_W];
    endfunction

    function automatic logic byte_matches(
        input logic [DATA_W-1:0] data,
        input logic [DATA_W-1:0] pat,
        input logic [DATA_W-1:0] wild
    );
        return (pat == wild) || (pat == data);
    endfunction

endpackage

// ===== hdl/wbps_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: input bytes, search results and configuration writes.
// Depends on wbps_pkg.
interface wbps_in_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;
    modport source(output valid, output found, output match_address, input ready);
    modport sink(input valid, input found, input match_address, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/wildcard_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// Wildcard byte pattern search. Takes one byte per cycle while the output is not
// stalled, with no bubbles between regions: the window is a chain of MAX_PATTERN
// cells that shift once per accepted byte and compare in parallel. The result
// of a region (found, match address) is produced in the cycle its last byte is
// accepted and appears on the output in the next cycle. The result sits in a
// registered output stage; the input stalls only
// while that result waits on a receiver that is not ready, and a result taken
// in the same cycle frees the stage for the next byte. Configuration is to be
// written only while no region is in progress. Depends on wbps_pkg, wbps_if
// and wbps_cell.
module wildcard_byte_pattern_search import wbps_pkg::*; #(
    parameter int MAX_PATTERN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wbps_in_if.sink     i_in,
    wbps_out_if.source  o_out,
    wbps_cfg_if.sink    i_cfg
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    // configuration registers
    logic [LEN_W-1:0]  r_pattern_length;
    logic [DATA_W-1:0] r_wildcard;
    logic [PAT_W-1:0]  r_pattern;
    logic [ADDR_W-1:0] r_base_address;
    logic              r_anchored;

    // region state
    logic [POS_W-1:0]  r_position;
    logic              r_match_seen;
    logic [POS_W-1:0]  r_match_offset;
    logic              r_prefix_mismatch;

    // output stage
    logic              r_out_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_match_address;

    logic [POS_W-1:0]  n_position;
    logic              n_match_seen;
    logic [POS_W-1:0]  n_match_offset;
    logic              n_prefix_mismatch;
    logic              n_found;
    logic [ADDR_W-1:0] n_match_address;

    logic              accept;
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  len_ext;
    logic              all_hit;
    logic              anchor_fail;
    logic              search_hit;

    logic [DATA_W-1:0] chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] hits;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;

    assign len     = (r_pattern_length > MAX_LEN) ? MAX_LEN : r_pattern_length;
    assign len_ext = POS_W'(len);

    assign chain[0] = i_in.data_byte;

    // cell j sees window entry j after the shift; it pairs with pattern byte len-1-j
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        t_cell_ctrl       ctrl;
        logic [LEN_W-1:0] pidx;

        assign pidx        = len - LEN_W'(1) - LEN_W'(j);
        assign ctrl.shift  = accept;
        assign ctrl.active = LEN_W'(j) < len;
        assign ctrl.pat    = pattern_byte(r_pattern, pidx[PAT_IDX_W-1:0]);
        assign ctrl.wild   = r_wildcard;

        wbps_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_byte (chain[j]),
            .o_byte (chain[j+1]),
            .o_hit  (hits[j])
        );
    end

    assign all_hit = &hits;

    always_comb begin
        n_position = (r_position == '1) ? r_position : r_position + POS_W'(1);

        anchor_fail = (r_position < len_ext) &&
                      !byte_matches(i_in.data_byte,
                                    pattern_byte(r_pattern, r_position[PAT_IDX_W-1:0]),
                                    r_wildcard);
        n_prefix_mismatch = r_prefix_mismatch || anchor_fail;

        search_hit = (len != '0) && (n_position >= len_ext) && !r_match_seen && all_hit;
        n_match_seen   = r_match_seen || search_hit;
        n_match_offset = search_hit ? (n_position - len_ext) : r_match_offset;

        if (r_anchored) begin
            n_found         = (len != '0) && !n_prefix_mismatch;
            n_match_address = r_base_address;
        end else begin
            n_found         = (len != '0) && n_match_seen;
            n_match_address = r_base_address + ADDR_W'(n_match_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_W'(1);
            r_wildcard       <= '0;
            r_pattern        <= '0;
            r_base_address   <= '0;
            r_anchored       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg.data[LEN_W-1:0];
                CFG_WILDCARD_BYTE:  r_wildcard       <= i_cfg.data[DATA_W-1:0];
                CFG_PATTERN_LOW:    r_pattern[PAT_W/2-1:0]     <= i_cfg.data;
                CFG_PATTERN_HIGH:   r_pattern[PAT_W-1:PAT_W/2] <= i_cfg.data;
                CFG_BASE_ADDRESS:   r_base_address   <= i_cfg.data;
                CFG_ANCHORED_MODE:  r_anchored       <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position        <= '0;
            r_match_seen      <= 1'b0;
            r_match_offset    <= '0;
            r_prefix_mismatch <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_position        <= '0;
                r_match_seen      <= 1'b0;
                r_match_offset    <= '0;
                r_prefix_mismatch <= 1'b0;
            end else begin
                r_position        <= n_position;
                r_match_seen      <= n_match_seen;
                r_match_offset    <= n_match_offset;
                r_prefix_mismatch <= n_prefix_mismatch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in.last_byte) begin
            r_found         <= n_found;
            r_match_address <= n_found ? n_match_address : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.match_address = r_match_address;

endmodule

// ===== hdl/wbps_cell.sv =====
`timescale 1ns / 1ps
// One window cell: holds a byte, passes it on to the next cell on each shift,
// and compares the byte it receives against its pattern byte. Uses wbps_pkg.
module wbps_cell import wbps_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_byte,
    output logic [DATA_W-1:0] o_byte,
    output logic              o_hit
);

    logic [DATA_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    // idle cells beyond the pattern length never veto a match
    assign o_hit  = !i_ctrl.active || byte_matches(i_byte, i_ctrl.pat, i_ctrl.wild);

endmodule

// ===== hdl/wbps_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the wildcard byte pattern search, bound to the top
// level. Depends on wbps_pkg and the top level's ports.
module wbps_checker import wbps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_found,
    input logic [ADDR_W-1:0] i_out_address
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_found) && $stable(i_out_address)))
        else $error("result changed while stalled");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_address == '0))
        else $error("address nonzero without a match");

    // every region end produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> i_out_valid)
        else $error("no result after last byte");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result without a last byte");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last_byte),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_found   (o_out.found),
    .i_out_address (o_out.match_address)
);
